// ----- hdl/pspa_pkg.sv -----
// Shared types, constants and the arctangent table for the polar step accumulator.
`timescale 1ns / 1ps

package pspa_pkg;

  // Command codes
  localparam logic [1:0] CMD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_SECOND = 2'd1;
  localparam logic [1:0] CMD_BOTH   = 2'd2;

  // Register indexes on the APB port (address bit 2)
  localparam logic REG_FIRST_RADIUS  = 1'b0;
  localparam logic REG_SECOND_RADIUS = 1'b1;

  // Reset value of both radii, 1.0 in Q8.8
  localparam logic [15:0] RADIUS_RESET = 16'd256;

  // Angle constants in degrees Q.6
  localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;

  // CORDIC sizing
  localparam int TABLE_LEN = 24;
  localparam int STEP_W    = 5;   // index into the arctangent table
  localparam int XY_W      = 18;  // CORDIC x/y datapath
  localparam int Z_W       = 26;  // residual angle, degrees Q.16
  localparam int DISP_W    = 18;  // displacement, Q.8
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 18'sd19899;

  // One request on the command channel
  typedef struct packed {
    logic [1:0]          command;
    logic signed [15:0]  first_angle;
    logic signed [15:0]  second_angle;
  } command_t;

  // One result on the point channel
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } point_t;

  // What a lane reports to the merging stage
  typedef struct packed {
    logic                     done;
    logic signed [DISP_W-1:0] dx;
    logic signed [DISP_W-1:0] dy;
  } lane_res_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_ADD_FIRST,
    ST_ADD_SECOND,
    ST_OUT
  } pspa_state_t;

  // atan(2^-i) in degrees Q.16, rounded
  function automatic logic [22:0] atan_deg(input logic [STEP_W-1:0] idx);
    logic [22:0] v;
    begin
      case (idx)
        5'd0:    v = 23'd2949120;
        5'd1:    v = 23'd1740967;
        5'd2:    v = 23'd919879;
        5'd3:    v = 23'd466945;
        5'd4:    v = 23'd234379;
        5'd5:    v = 23'd117304;
        5'd6:    v = 23'd58666;
        5'd7:    v = 23'd29335;
        5'd8:    v = 23'd14668;
        5'd9:    v = 23'd7334;
        5'd10:   v = 23'd3667;
        5'd11:   v = 23'd1833;
        5'd12:   v = 23'd917;
        5'd13:   v = 23'd458;
        5'd14:   v = 23'd229;
        5'd15:   v = 23'd115;
        5'd16:   v = 23'd57;
        5'd17:   v = 23'd29;
        5'd18:   v = 23'd14;
        5'd19:   v = 23'd7;
        5'd20:   v = 23'd4;
        5'd21:   v = 23'd2;
        5'd22:   v = 23'd1;
        default: v = 23'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- hdl/pspa_lane.sv -----
// One arm lane: angle reduction, iterative CORDIC, scaling by the arm radius.
`timescale 1ns / 1ps

module pspa_lane #(
  parameter int NUM_STEPS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [15:0]                radius,
  input  logic signed [15:0]         angle,
  output pspa_pkg::lane_res_t        res
);
  import pspa_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  logic                      busy;
  logic                      mul_go;
  logic                      rnd_go;
  logic                      done;
  logic [STEP_W-1:0]         cnt;
  logic                      flip;
  logic signed [XY_W-1:0]    x;
  logic signed [XY_W-1:0]    y;
  logic signed [Z_W-1:0]     z;
  logic signed [32:0]        prod_x;
  logic signed [32:0]        prod_y;
  logic signed [DISP_W-1:0]  disp_x;
  logic signed [DISP_W-1:0]  disp_y;

  logic signed [16:0]        red;
  logic                      red_flip;
  logic signed [XY_W-1:0]    dx;
  logic signed [XY_W-1:0]    dy;
  logic signed [Z_W-1:0]     at;
  logic signed [XY_W-1:0]    xf;
  logic signed [XY_W-1:0]    yf;
  logic signed [15:0]        cos_c;
  logic signed [15:0]        sin_c;
  logic signed [16:0]        rad_s;
  logic signed [32:0]        rnd_x;
  logic signed [32:0]        rnd_y;

  // Reduce the angle to [-90, 90] degrees, noting a half-turn flip
  always_comb begin
    red      = {angle[15], angle};
    red_flip = 1'b0;
    if (red >= FULL_TURN) begin
      red = red - FULL_TURN;
    end else if (red < 0) begin
      red = red + FULL_TURN;
      if (red < 0) begin
        red = red + FULL_TURN;
      end
    end
    if (red > HALF_TURN) begin
      red = red - FULL_TURN;
    end
    if (red > QUARTER_TURN) begin
      red      = red - HALF_TURN;
      red_flip = 1'b1;
    end else if (red < -QUARTER_TURN) begin
      red      = red + HALF_TURN;
      red_flip = 1'b1;
    end
  end

  // Shift terms and table entry for the current micro-rotation
  assign dx = y >>> cnt;
  assign dy = x >>> cnt;
  assign at = signed'({3'b000, atan_deg(cnt)});

  // Undo the flip and clamp to Q1.15
  always_comb begin
    xf = flip ? -x : x;
    yf = flip ? -y : y;
    if (xf > 18'sd32767) begin
      cos_c = 16'sd32767;
    end else if (xf < -18'sd32767) begin
      cos_c = -16'sd32767;
    end else begin
      cos_c = xf[15:0];
    end
    if (yf > 18'sd32767) begin
      sin_c = 16'sd32767;
    end else if (yf < -18'sd32767) begin
      sin_c = -16'sd32767;
    end else begin
      sin_c = yf[15:0];
    end
  end

  assign rad_s = signed'({1'b0, radius});
  assign rnd_x = prod_x + 33'sd16384;
  assign rnd_y = prod_y + 33'sd16384;

  // Lane control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      mul_go <= 1'b0;
      rnd_go <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      mul_go <= 1'b0;
      rnd_go <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      mul_go <= busy && (cnt == LAST_STEP);
      rnd_go <= mul_go;
      if (rnd_go) begin
        done <= 1'b1;
      end
      if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // CORDIC datapath, one micro-rotation a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= Z_W'(red) <<< 10;
      flip <= red_flip;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  // Scale by the radius, then round half up back to Q.8
  always_ff @(posedge clk) begin
    if (mul_go) begin
      prod_x <= rad_s * cos_c;
      prod_y <= rad_s * sin_c;
    end
    if (rnd_go) begin
      disp_x <= rnd_x[32:15];
      disp_y <= rnd_y[32:15];
    end
  end

  assign res.done = done;
  assign res.dx   = disp_x;
  assign res.dy   = disp_y;

endmodule

// ----- hdl/pspa_merge.sv -----
// Merging stage: holds the shared end-point and adds lane displacements with saturation.
`timescale 1ns / 1ps

module pspa_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               add,
  input  logic signed [pspa_pkg::DISP_W-1:0] dx,
  input  logic signed [pspa_pkg::DISP_W-1:0] dy,
  output logic signed [31:0]                 pos_x,
  output logic signed [31:0]                 pos_y
);
  import pspa_pkg::*;

  localparam logic signed [32:0] POS_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] POS_MIN = -33'sh0_8000_0000;

  logic signed [32:0] sum_x;
  logic signed [32:0] sum_y;
  logic signed [31:0] pos_x_next;
  logic signed [31:0] pos_y_next;

  // Wide sums, then clamp to the 32-bit range
  always_comb begin
    sum_x = 33'(pos_x) + 33'(dx);
    sum_y = 33'(pos_y) + 33'(dy);
    if (sum_x > POS_MAX) begin
      pos_x_next = POS_MAX[31:0];
    end else if (sum_x < POS_MIN) begin
      pos_x_next = POS_MIN[31:0];
    end else begin
      pos_x_next = sum_x[31:0];
    end
    if (sum_y > POS_MAX) begin
      pos_y_next = POS_MAX[31:0];
    end else if (sum_y < POS_MIN) begin
      pos_y_next = POS_MIN[31:0];
    end else begin
      pos_y_next = sum_y[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
    end else if (add) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
    end
  end

endmodule

// ----- hdl/polar_step_position_accumulator.sv -----
// A command runs the iterative CORDIC in both lanes side by side (steps capped at 24),
//   one micro-rotation per cycle, then radius scaling, rounding and the two merge adds;
//   a new command is taken only after the point has been loaded into the output register.
// A finished point waits in an output register while the next command is taken.
// Reset (synchronous, active high) clears the end-point to zero and both radii to 1.0.
`timescale 1ns / 1ps

module polar_step_position_accumulator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  pspa_pkg::command_t  cmd,
  output logic                point_valid,
  input  logic                point_ready,
  output pspa_pkg::point_t    point,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pspa_pkg::*;

  localparam int NUM_STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  pspa_state_t      state;
  pspa_state_t      state_next;
  logic [15:0]      first_radius;
  logic [15:0]      second_radius;
  logic [1:0]       cmd_code;
  point_t           point_q;

  logic             start;
  logic             out_load;
  logic             use_first;
  logic             use_second;
  logic             merge_add;
  logic signed [DISP_W-1:0] merge_dx;
  logic signed [DISP_W-1:0] merge_dy;
  logic signed [31:0]       pos_x;
  logic signed [31:0]       pos_y;
  lane_res_t        res_first;
  lane_res_t        res_second;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SECOND_RADIUS) ? {16'd0, second_radius}
                                                  : {16'd0, first_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_radius  <= RADIUS_RESET;
      second_radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_FIRST_RADIUS) begin
        first_radius <= pwdata[15:0];
      end else begin
        second_radius <= pwdata[15:0];
      end
    end
  end

  // Lanes, one per arm
  pspa_lane #(.NUM_STEPS(NUM_STEPS)) u_lane_first (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .radius (first_radius),
    .angle  (cmd.first_angle),
    .res    (res_first)
  );

  pspa_lane #(.NUM_STEPS(NUM_STEPS)) u_lane_second (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .radius (second_radius),
    .angle  (cmd.second_angle),
    .res    (res_second)
  );

  // Which arms the held command moves
  assign use_first  = (cmd_code == CMD_FIRST)  || (cmd_code == CMD_BOTH);
  assign use_second = (cmd_code == CMD_SECOND) || (cmd_code == CMD_BOTH);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (res_first.done && res_second.done) begin
          state_next = ST_ADD_FIRST;
        end
      end
      ST_ADD_FIRST:  state_next = ST_ADD_SECOND;
      ST_ADD_SECOND: state_next = ST_OUT;
      ST_OUT: begin
        if (!point_valid || point_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cmd_ready = 1'b0;
    merge_add = 1'b0;
    merge_dx  = res_first.dx;
    merge_dy  = res_first.dy;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: cmd_ready = 1'b1;
      ST_CALC: ;
      ST_ADD_FIRST: merge_add = use_first;
      ST_ADD_SECOND: begin
        merge_add = use_second;
        merge_dx  = res_second.dx;
        merge_dy  = res_second.dy;
      end
      ST_OUT: out_load = !point_valid || point_ready;
      default: ;
    endcase
  end

  assign start = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_code <= cmd.command;
    end
  end

  // Shared end-point
  pspa_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .add   (merge_add),
    .dx    (merge_dx),
    .dy    (merge_dy),
    .pos_x (pos_x),
    .pos_y (pos_y)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (out_load) begin
      point_valid <= 1'b1;
    end else if (point_ready) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      point_q.point_x <= pos_x;
      point_q.point_y <= pos_y;
    end
  end

  assign point = point_q;

endmodule
